@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the scheduler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define APTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define APTS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

@@ rtl/apts_pkg.sv @@
package apts_pkg;

  localparam int DEF_MAX_TASKS       = 16;
  localparam int DEF_EVENTS_PER_TASK = 4;
  localparam int DEF_TIME_BITS       = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ADMIT = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] ST_EMPTY   = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_WAITING = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic CFG_AGING = 1'b0;
  localparam logic CFG_FLOOR = 1'b1;

  typedef struct packed {
    logic latch;
    logic load;
    logic admit;
    logic age;
    logic scan_clr;
    logic scan_step;
    logic preempt;
    logic take;
    logic ev_rd;
    logic io_block;
    logic exec;
    logic io_rd;
    logic io_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       own_vld;
    logic       best_vld;
    logic       io_due;
    logic       idx_wait;
    logic       out_free;
  } sts_t;

endpackage

@@ rtl/apts_dp.sv @@
`include "assert_macros.svh"

module apts_dp #(
  parameter int MAX_TASKS       = apts_pkg::DEF_MAX_TASKS,
  parameter int EVENTS_PER_TASK = apts_pkg::DEF_EVENTS_PER_TASK,
  parameter int TIME_BITS       = apts_pkg::DEF_TIME_BITS,
  localparam int TW  = $clog2(MAX_TASKS),
  localparam int EW  = (EVENTS_PER_TASK > 1) ? $clog2(EVENTS_PER_TASK) : 1,
  localparam int NEW = $clog2(EVENTS_PER_TASK + 1),
  localparam int AW  = TW + EW,
  localparam int DEPTH = 2 ** AW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         task_id_i,
  input  logic [7:0]         priority_req_i,
  input  logic [15:0]        burst_len_i,
  input  logic [1:0]         event_slot_i,
  input  logic [15:0]        io_start_i,
  input  logic [15:0]        io_length_i,
  input  logic [TW-1:0]      idx_i,
  input  apts_pkg::cmd_t     cmd_i,
  output apts_pkg::sts_t     sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         running_task_o,
  output logic               cpu_idle_o,
  output logic               finished_valid_o,
  output logic [3:0]         finished_task_o,
  output logic [15:0]        turnaround_o,
  output logic [15:0]        wait_ticks_o
);

  logic [2:0]           status_q [MAX_TASKS];
  logic [7:0]           prio_q   [MAX_TASKS];
  logic [7:0]           age_q    [MAX_TASKS];
  logic [15:0]          left_q   [MAX_TASKS];
  logic [15:0]          done_q   [MAX_TASKS];
  logic [15:0]          burst_q  [MAX_TASKS];
  logic [TIME_BITS-1:0] arr_q    [MAX_TASKS];
  logic [15:0]          blk_q    [MAX_TASKS];
  logic [NEW-1:0]       nev_q    [MAX_TASKS];
  logic [NEW-1:0]       etot_q   [MAX_TASKS];

  logic [7:0] aged_cnt  [MAX_TASKS];
  logic [7:0] aged_prio [MAX_TASKS];

  logic [15:0] begin_mem [DEPTH];
  logic [15:0] left_mem  [DEPTH];
  logic [15:0] rd_begin_q, rd_left_q;

  logic [TW-1:0]        owner_q, best_q;
  logic                 own_vld_q, best_vld_q;
  logic [TIME_BITS-1:0] tick_q;
  logic [7:0]           aging_q, floor_q;

  logic [1:0]  op_q;
  logic [3:0]  id_q;
  logic [7:0]  preq_q;
  logic [15:0] creq_q;
  logic [1:0]  slot_q;
  logic [15:0] start_q;
  logic [15:0] len_q;

  logic        out_vld_q, out_idle_q, out_fin_q;
  logic [3:0]  out_run_q, out_ftask_q;
  logic [15:0] out_turn_q, out_wait_q;

  logic [TW-1:0]        idt;
  logic [EW-1:0]        slt;
  logic                 id_free, load_ok, admit_ok;
  logic                 take_idx, preempt_ok, io_due, fin_now, idx_wait, idx_has_ev;
  logic [AW-1:0]        idx_addr, own_addr, rd_addr;
  logic [15:0]          burst_eff;
  logic [TIME_BITS-1:0] tdiff;
  logic [15:0]          turn16, wait16;

  assign idt      = TW'(id_q);
  assign slt      = EW'(slot_q);
  assign id_free  = (status_q[idt] == apts_pkg::ST_EMPTY) || (status_q[idt] == apts_pkg::ST_DONE);
  assign admit_ok = (int'(id_q) < MAX_TASKS) && id_free;
  assign load_ok  = admit_ok && (int'(slot_q) < EVENTS_PER_TASK)
                  && (int'(slot_q) <= int'(etot_q[idt]));
  assign burst_eff = (creq_q == 16'd0) ? 16'd1 : creq_q;

  assign take_idx   = (status_q[idx_i] == apts_pkg::ST_READY)
                    && (!best_vld_q || (prio_q[idx_i] < prio_q[best_q]));
  assign preempt_ok = own_vld_q && best_vld_q && (prio_q[best_q] < prio_q[owner_q]);
  assign io_due     = own_vld_q && (nev_q[owner_q] < etot_q[owner_q])
                    && (done_q[owner_q] == rd_begin_q);
  assign idx_wait   = status_q[idx_i] == apts_pkg::ST_WAITING;
  assign idx_has_ev = nev_q[idx_i] < etot_q[idx_i];
  assign fin_now    = own_vld_q && (left_q[owner_q] == 16'd0);

  assign idx_addr = {idx_i, EW'(nev_q[idx_i])};
  assign own_addr = {owner_q, EW'(nev_q[owner_q])};
  assign rd_addr  = cmd_i.ev_rd ? own_addr : idx_addr;

  assign tdiff  = tick_q + TIME_BITS'(1) - arr_q[owner_q];
  assign turn16 = 16'(tdiff);
  assign wait16 = turn16 - burst_q[owner_q] - blk_q[owner_q];

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      aged_cnt[i]  = age_q[i] + 8'd1;
      aged_prio[i] = prio_q[i];
      if (aged_cnt[i] >= aging_q) begin
        aged_cnt[i] = 8'd0;
        if (prio_q[i] > floor_q) aged_prio[i] = prio_q[i] - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        status_q[i] <= apts_pkg::ST_EMPTY;
        nev_q[i]    <= '0;
        etot_q[i]   <= '0;
      end
      own_vld_q  <= 1'b0;
      owner_q    <= '0;
      best_vld_q <= 1'b0;
      tick_q     <= '0;
      aging_q    <= 8'd10;
      floor_q    <= 8'd0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == apts_pkg::CFG_AGING) aging_q <= cfg_wdata_i;
        else floor_q <= cfg_wdata_i;
      end
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      if (cmd_i.load && load_ok) etot_q[idt] <= NEW'(slot_q) + NEW'(1);
      if (cmd_i.admit && admit_ok) begin
        status_q[idt] <= apts_pkg::ST_READY;
        nev_q[idt]    <= '0;
      end
      if (cmd_i.scan_clr) best_vld_q <= 1'b0;
      if (cmd_i.scan_step && take_idx) best_vld_q <= 1'b1;
      if (cmd_i.preempt && preempt_ok) begin
        status_q[owner_q] <= apts_pkg::ST_READY;
        own_vld_q         <= 1'b0;
      end
      if (cmd_i.take && !own_vld_q && best_vld_q) begin
        owner_q          <= best_q;
        own_vld_q        <= 1'b1;
        status_q[best_q] <= apts_pkg::ST_RUNNING;
      end
      if (cmd_i.io_block && io_due) begin
        status_q[owner_q] <= apts_pkg::ST_WAITING;
        own_vld_q         <= 1'b0;
      end
      if (cmd_i.io_wr && idx_wait) begin
        if (!idx_has_ev) status_q[idx_i] <= apts_pkg::ST_READY;
        else if (rd_left_q <= 16'd1) begin
          status_q[idx_i] <= apts_pkg::ST_READY;
          nev_q[idx_i]    <= nev_q[idx_i] + NEW'(1);
        end
      end
      if (cmd_i.finish) begin
        if (fin_now) begin
          status_q[owner_q] <= apts_pkg::ST_DONE;
          etot_q[owner_q]   <= '0;
          nev_q[owner_q]    <= '0;
          own_vld_q         <= 1'b0;
        end
        out_vld_q <= 1'b1;
        tick_q    <= tick_q + TIME_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= operation_i;
      id_q    <= task_id_i;
      preq_q  <= priority_req_i;
      creq_q  <= burst_len_i;
      slot_q  <= event_slot_i;
      start_q <= io_start_i;
      len_q   <= io_length_i;
    end
    if (cmd_i.admit && admit_ok) begin
      prio_q[idt]  <= preq_q;
      age_q[idt]   <= 8'd0;
      left_q[idt]  <= burst_eff;
      done_q[idt]  <= 16'd0;
      burst_q[idt] <= burst_eff;
      arr_q[idt]   <= tick_q;
      blk_q[idt]   <= 16'd0;
    end
    if (cmd_i.age) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (status_q[i] == apts_pkg::ST_READY) begin
          age_q[i]  <= aged_cnt[i];
          prio_q[i] <= aged_prio[i];
        end
      end
    end
    if (cmd_i.scan_step && take_idx) best_q <= idx_i;
    if (cmd_i.take && !own_vld_q && best_vld_q) age_q[best_q] <= 8'd0;
    if (cmd_i.exec && own_vld_q) begin
      left_q[owner_q] <= left_q[owner_q] - 16'd1;
      done_q[owner_q] <= done_q[owner_q] + 16'd1;
    end
    if (cmd_i.io_wr && idx_wait && idx_has_ev && (blk_q[idx_i] != 16'hFFFF)) begin
      blk_q[idx_i] <= blk_q[idx_i] + 16'd1;
    end
    if (cmd_i.finish) begin
      out_run_q   <= own_vld_q ? 4'(owner_q) : 4'd0;
      out_idle_q  <= !own_vld_q;
      out_fin_q   <= fin_now;
      out_ftask_q <= fin_now ? 4'(owner_q) : 4'd0;
      out_turn_q  <= fin_now ? turn16 : 16'd0;
      out_wait_q  <= fin_now ? wait16 : 16'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      begin_mem[{idt, slt}] <= start_q;
      left_mem[{idt, slt}]  <= (len_q == 16'd0) ? 16'd1 : len_q;
    end else if (cmd_i.io_wr && idx_wait && idx_has_ev) begin
      left_mem[idx_addr] <= (rd_left_q <= 16'd1) ? 16'd0 : rd_left_q - 16'd1;
    end
    if (cmd_i.ev_rd || cmd_i.io_rd) begin
      rd_begin_q <= begin_mem[rd_addr];
      rd_left_q  <= left_mem[rd_addr];
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.own_vld  = own_vld_q;
  assign sts_o.best_vld = best_vld_q;
  assign sts_o.io_due   = io_due;
  assign sts_o.idx_wait = idx_wait;
  assign sts_o.out_free = !out_vld_q || !out_stall_i;

  assign out_valid_o      = out_vld_q;
  assign running_task_o   = out_run_q;
  assign cpu_idle_o       = out_idle_q;
  assign finished_valid_o = out_fin_q;
  assign finished_task_o  = out_ftask_q;
  assign turnaround_o     = out_turn_q;
  assign wait_ticks_o     = out_wait_q;

  `APTS_ASSERT(a_owner_running, clk_i, rst_ni,
    own_vld_q |-> status_q[owner_q] == apts_pkg::ST_RUNNING, "owner not in running state")
  `APTS_ASSERT(a_fin_is_runner, clk_i, rst_ni,
    (out_vld_q && out_fin_q) |-> (!out_idle_q && out_ftask_q == out_run_q),
    "finished task differs from running task")

endmodule

@@ rtl/apts_ctrl.sv @@
`include "assert_macros.svh"

module apts_ctrl #(
  parameter int MAX_TASKS = apts_pkg::DEF_MAX_TASKS,
  localparam int TW = $clog2(MAX_TASKS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  apts_pkg::sts_t sts_i,
  output apts_pkg::cmd_t cmd_o,
  output logic [TW-1:0]  idx_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_PREEMPT = 4'd3;
  localparam logic [3:0] S_TAKE    = 4'd4;
  localparam logic [3:0] S_EVRD    = 4'd5;
  localparam logic [3:0] S_EVCHK   = 4'd6;
  localparam logic [3:0] S_EXEC    = 4'd7;
  localparam logic [3:0] S_IORD    = 4'd8;
  localparam logic [3:0] S_IOWR    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  localparam logic [TW-1:0] LAST_IDX = TW'(MAX_TASKS - 1);

  logic [3:0]    state_q, state_d;
  logic [TW-1:0] idx_q, idx_d;
  logic          rescan_q, rescan_d;
  logic          last;

  assign last       = idx_q == LAST_IDX;
  assign in_stall_o = state_q != S_IDLE;
  assign idx_o      = idx_q;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    idx_d    = idx_q;
    rescan_d = rescan_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (sts_i.op)
          apts_pkg::OP_LOAD:  cmd_o.load  = 1'b1;
          apts_pkg::OP_ADMIT: cmd_o.admit = 1'b1;
          apts_pkg::OP_TICK: begin
            cmd_o.age      = 1'b1;
            cmd_o.scan_clr = 1'b1;
            idx_d          = '0;
            rescan_d       = 1'b0;
            state_d        = S_SCAN;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = rescan_q ? S_TAKE : S_PREEMPT;
        end else begin
          idx_d = idx_q + TW'(1);
        end
      end
      S_PREEMPT: begin
        cmd_o.preempt = 1'b1;
        state_d       = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        state_d    = (sts_i.own_vld || sts_i.best_vld) ? S_EVRD : S_EXEC;
      end
      S_EVRD: begin
        cmd_o.ev_rd = 1'b1;
        state_d     = S_EVCHK;
      end
      S_EVCHK: begin
        cmd_o.io_block = 1'b1;
        if (sts_i.io_due) begin
          cmd_o.scan_clr = 1'b1;
          rescan_d       = 1'b1;
          idx_d          = '0;
          state_d        = S_SCAN;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        idx_d      = '0;
        state_d    = S_IORD;
      end
      S_IORD: begin
        if (sts_i.idx_wait) begin
          cmd_o.io_rd = 1'b1;
          state_d     = S_IOWR;
        end else if (last) begin
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + TW'(1);
        end
      end
      S_IOWR: begin
        cmd_o.io_wr = 1'b1;
        if (last) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + TW'(1);
          state_d = S_IORD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      rescan_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rescan_q <= rescan_d;
    end
  end

  `APTS_ASSERT(a_accept_decodes, clk_i, rst_ni,
    (in_valid_i && !in_stall_o) |=> state_q == S_DECODE, "accepted request not decoded")
  `APTS_ASSERT_NEVER(a_scan_wrap, clk_i, rst_ni,
    (state_q == S_SCAN) && (int'(idx_q) >= MAX_TASKS), "scan index beyond table")

endmodule

@@ rtl/aging_priority_task_scheduler_top.sv @@
// Preemptive priority task scheduler with aging. Requests are taken one at a time on the
// input channel; io event loads and admits give no result. A tick gives one result: it
// ages the ready tasks, makes one pass over the task table for selection, may preempt,
// dispatches, then makes one pass for io progress; each task sent to io at dispatch
// brings another selection pass. The selection pass walks the table one slot a cycle; so
// does the io pass, but the slot of a task waiting in io takes a read and a write step.
// io events sit in a single-port memory read one entry per cycle. A result waiting on the
// output does not hold off new requests, only the closing cycle of the next tick.
module aging_priority_task_scheduler_top #(
  parameter int MAX_TASKS       = apts_pkg::DEF_MAX_TASKS,
  parameter int EVENTS_PER_TASK = apts_pkg::DEF_EVENTS_PER_TASK,
  parameter int TIME_BITS       = apts_pkg::DEF_TIME_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  task_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] burst_len_i,
  input  logic [1:0]  event_slot_i,
  input  logic [15:0] io_start_i,
  input  logic [15:0] io_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  running_task_o,
  output logic        cpu_idle_o,
  output logic        finished_valid_o,
  output logic [3:0]  finished_task_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] wait_ticks_o
);

  localparam int TW = $clog2(MAX_TASKS);

  apts_pkg::cmd_t cmd;
  apts_pkg::sts_t sts;
  logic [TW-1:0]  idx;

  apts_ctrl #(
    .MAX_TASKS(MAX_TASKS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .idx_o     (idx)
  );

  apts_dp #(
    .MAX_TASKS      (MAX_TASKS),
    .EVENTS_PER_TASK(EVENTS_PER_TASK),
    .TIME_BITS      (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .task_id_i       (task_id_i),
    .priority_req_i  (priority_req_i),
    .burst_len_i     (burst_len_i),
    .event_slot_i    (event_slot_i),
    .io_start_i      (io_start_i),
    .io_length_i     (io_length_i),
    .idx_i           (idx),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .running_task_o  (running_task_o),
    .cpu_idle_o      (cpu_idle_o),
    .finished_valid_o(finished_valid_o),
    .finished_task_o (finished_task_o),
    .turnaround_o    (turnaround_o),
    .wait_ticks_o    (wait_ticks_o)
  );

endmodule

@@ dv/apts_sched_checker.sv @@
`timescale 1ns / 100ps

module apts_sched_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  task_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] burst_len_i,
  input  logic [1:0]  event_slot_i,
  input  logic [15:0] io_start_i,
  input  logic [15:0] io_length_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  running_task_i,
  input  logic        cpu_idle_i,
  input  logic        finished_valid_i,
  input  logic [3:0]  finished_task_i,
  input  logic [15:0] turnaround_i,
  input  logic [15:0] wait_ticks_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NTASK = apts_pkg::DEF_MAX_TASKS;
  localparam int NEV   = apts_pkg::DEF_EVENTS_PER_TASK;

  typedef struct packed {
    logic [3:0]  run_task;
    logic        idle;
    logic        fin;
    logic [3:0]  fin_task;
    logic [15:0] turn;
    logic [15:0] wait_t;
  } tick_result_t;

  tick_result_t tick_results_q[$];

  logic [7:0]  age_step, prio_floor;
  logic [2:0]  status_q [NTASK];
  logic [7:0]  prio_q [NTASK];
  logic [7:0]  age_q [NTASK];
  logic [15:0] left_q [NTASK];
  logic [15:0] done_q [NTASK];
  logic [15:0] burst_q [NTASK];
  logic [15:0] arrive_q [NTASK];
  logic [15:0] blocked_q [NTASK];
  logic [2:0]  next_ev_q [NTASK];
  logic [2:0]  ev_count_q [NTASK];
  logic [15:0] ev_begin_q [NTASK][NEV];
  logic [15:0] ev_left_q [NTASK][NEV];
  bit          owner_vld;
  logic [3:0]  owner;
  logic [15:0] tick_now;

  assign pending_o = tick_results_q.size();

  function automatic int best_ready();
    int b;
    b = NTASK;
    for (int i = 0; i < NTASK; i++)
      if (status_q[i] == apts_pkg::ST_READY && (b == NTASK || prio_q[i] < prio_q[b])) b = i;
    return b;
  endfunction

  function automatic bit io_starts(int t);
    int e;
    e = int'(next_ev_q[t]);
    if (e >= int'(ev_count_q[t]) || e >= NEV) return 1'b0;
    return done_q[t] == ev_begin_q[t][e];
  endfunction

  function automatic tick_result_t schedule_tick();
    tick_result_t r;
    int b;
    int e;
    r = '0;
    for (int i = 0; i < NTASK; i++) begin
      if (status_q[i] != apts_pkg::ST_READY) continue;
      age_q[i] = age_q[i] + 8'd1;
      if (age_q[i] >= age_step) begin
        age_q[i] = 8'd0;
        if (prio_q[i] > prio_floor) prio_q[i] = prio_q[i] - 8'd1;
      end
    end
    if (owner_vld) begin
      b = best_ready();
      if (b < NTASK && b != int'(owner) && prio_q[b] < prio_q[owner]) begin
        status_q[owner] = apts_pkg::ST_READY;
        owner_vld = 1'b0;
      end
    end
    while (1'b1) begin
      if (!owner_vld) begin
        b = best_ready();
        if (b >= NTASK) break;
        owner = b[3:0];
        owner_vld = 1'b1;
        status_q[b] = apts_pkg::ST_RUNNING;
        age_q[b] = 8'd0;
      end
      if (io_starts(int'(owner))) begin
        status_q[owner] = apts_pkg::ST_WAITING;
        owner_vld = 1'b0;
      end else begin
        break;
      end
    end
    if (owner_vld) begin
      left_q[owner] = left_q[owner] - 16'd1;
      done_q[owner] = done_q[owner] + 16'd1;
    end
    r.run_task = owner_vld ? owner : 4'd0;
    r.idle = !owner_vld;
    for (int i = 0; i < NTASK; i++) begin
      if (status_q[i] != apts_pkg::ST_WAITING) continue;
      e = int'(next_ev_q[i]);
      if (e >= int'(ev_count_q[i]) || e >= NEV) begin
        status_q[i] = apts_pkg::ST_READY;
        continue;
      end
      if (blocked_q[i] != 16'hFFFF) blocked_q[i] = blocked_q[i] + 16'd1;
      if (ev_left_q[i][e] <= 16'd1) begin
        ev_left_q[i][e] = 16'd0;
        next_ev_q[i] = 3'(e + 1);
        status_q[i] = apts_pkg::ST_READY;
      end else begin
        ev_left_q[i][e] = ev_left_q[i][e] - 16'd1;
      end
    end
    if (owner_vld && left_q[owner] == 16'd0) begin
      status_q[owner] = apts_pkg::ST_DONE;
      r.fin = 1'b1;
      r.fin_task = owner;
      r.turn = tick_now + 16'd1 - arrive_q[owner];
      r.wait_t = r.turn - burst_q[owner] - blocked_q[owner];
      ev_count_q[owner] = 3'd0;
      next_ev_q[owner] = 3'd0;
      owner_vld = 1'b0;
    end
    tick_now = tick_now + 16'd1;
    return r;
  endfunction

  task automatic take_request();
    int id;
    int sl;
    id = int'(task_id_i);
    sl = int'(event_slot_i);
    case (operation_i)
      apts_pkg::OP_LOAD: begin
        if ((status_q[id] == apts_pkg::ST_EMPTY || status_q[id] == apts_pkg::ST_DONE)
            && sl < NEV && sl <= int'(ev_count_q[id])) begin
          ev_begin_q[id][sl] = io_start_i;
          ev_left_q[id][sl] = (io_length_i == 16'd0) ? 16'd1 : io_length_i;
          ev_count_q[id] = 3'(sl + 1);
        end
      end
      apts_pkg::OP_ADMIT: begin
        if (status_q[id] == apts_pkg::ST_EMPTY || status_q[id] == apts_pkg::ST_DONE) begin
          status_q[id] = apts_pkg::ST_READY;
          prio_q[id] = priority_req_i;
          age_q[id] = 8'd0;
          left_q[id] = (burst_len_i == 16'd0) ? 16'd1 : burst_len_i;
          burst_q[id] = left_q[id];
          done_q[id] = 16'd0;
          arrive_q[id] = tick_now;
          blocked_q[id] = 16'd0;
          next_ev_q[id] = 3'd0;
        end
      end
      apts_pkg::OP_TICK: tick_results_q.push_back(schedule_tick());
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t exp_r;
    if (!rst_ni) begin
      age_step = 8'd10;
      prio_floor = 8'd0;
      for (int i = 0; i < NTASK; i++) begin
        status_q[i] = apts_pkg::ST_EMPTY;
        prio_q[i] = 8'd0;
        age_q[i] = 8'd0;
        left_q[i] = 16'd0;
        done_q[i] = 16'd0;
        burst_q[i] = 16'd0;
        arrive_q[i] = 16'd0;
        blocked_q[i] = 16'd0;
        next_ev_q[i] = 3'd0;
        ev_count_q[i] = 3'd0;
        for (int k = 0; k < NEV; k++) begin
          ev_begin_q[i][k] = 16'd0;
          ev_left_q[i][k] = 16'd0;
        end
      end
      owner_vld = 1'b0;
      owner = 4'd0;
      tick_now = 16'd0;
      tick_results_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == apts_pkg::CFG_AGING) age_step = cfg_wdata_i;
        else prio_floor = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (tick_results_q.size() == 0) begin
          $error("result with no tick outstanding");
          fail_count_o++;
        end else begin
          exp_r = tick_results_q.pop_front();
          check_field("running_task", exp_r.run_task, running_task_i);
          check_field("cpu_idle", exp_r.idle, cpu_idle_i);
          check_field("finished_valid", exp_r.fin, finished_valid_i);
          check_field("finished_task", exp_r.fin_task, finished_task_i);
          check_field("turnaround", exp_r.turn, turnaround_i);
          check_field("wait_ticks", exp_r.wait_t, wait_ticks_i);
        end
      end
      if (in_valid_i && !in_stall_i) take_request();
    end
  end

endmodule

@@ dv/tb_aging_priority_task_scheduler_top.sv @@
`timescale 1ns / 100ps

module tb_aging_priority_task_scheduler_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = apts_pkg::OP_TICK;
  logic [3:0]  task_id = '0;
  logic [7:0]  priority_req = '0;
  logic [15:0] burst_len = 16'd1;
  logic [1:0]  event_slot = '0;
  logic [15:0] io_start = '0;
  logic [15:0] io_length = 16'd1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  running_task;
  logic        cpu_idle;
  logic        finished_valid;
  logic [3:0]  finished_task;
  logic [15:0] turnaround;
  logic [15:0] wait_ticks;
  int          fail_count;
  int          pending;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;

  always #10 clk_i = ~clk_i;

  aging_priority_task_scheduler_top dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .task_id_i(task_id), .priority_req_i(priority_req),
    .burst_len_i(burst_len), .event_slot_i(event_slot), .io_start_i(io_start),
    .io_length_i(io_length),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .running_task_o(running_task), .cpu_idle_o(cpu_idle),
    .finished_valid_o(finished_valid), .finished_task_o(finished_task),
    .turnaround_o(turnaround), .wait_ticks_o(wait_ticks)
  );

  apts_sched_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .operation_i(operation), .task_id_i(task_id), .priority_req_i(priority_req),
    .burst_len_i(burst_len), .event_slot_i(event_slot), .io_start_i(io_start),
    .io_length_i(io_length),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .running_task_i(running_task), .cpu_idle_i(cpu_idle),
    .finished_valid_i(finished_valid), .finished_task_i(finished_task),
    .turnaround_i(turnaround), .wait_ticks_i(wait_ticks),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_aging_priority_task_scheduler_top: FAIL");
      $finish;
    end
  end

  // result side: random stall plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = 500;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  task automatic send(logic [1:0] op, logic [3:0] id, logic [7:0] prio, logic [15:0] burst,
                      logic [1:0] slot, logic [15:0] start, logic [15:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    operation <= op;
    task_id <= id;
    priority_req <= prio;
    burst_len <= burst;
    event_slot <= slot;
    io_start <= start;
    io_length <= len;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic tick();
    send(apts_pkg::OP_TICK, 4'($urandom), 8'($urandom), 16'($urandom), 2'($urandom),
         16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // io events in slot order, then the admit
  task automatic new_task();
    logic [3:0] id;
    logic [15:0] burst;
    int n;
    id = 4'($urandom);
    burst = 16'($urandom_range(1, 24));
    n = $urandom_range(0, 4);
    for (int s = 0; s < n; s++)
      send(apts_pkg::OP_LOAD, id, 8'($urandom), 16'($urandom), 2'(s),
           16'($urandom_range(0, int'(burst))), 16'($urandom_range(0, 8)));
    send(apts_pkg::OP_ADMIT, id, 8'($urandom), burst, 2'($urandom), 16'($urandom),
         16'($urandom));
  endtask

  task automatic noise();
    logic [15:0] burst;
    burst = ($urandom_range(49) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
    case ($urandom_range(3))
      0: send(apts_pkg::OP_LOAD, 4'($urandom), 8'($urandom), 16'($urandom), 2'($urandom),
              16'($urandom),
              ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)));
      1: send(apts_pkg::OP_ADMIT, 4'($urandom), 8'($urandom), burst, 2'($urandom),
              16'($urandom), 16'($urandom));
      2: send(OP_UNUSED, 4'($urandom), 8'($urandom), 16'($urandom), 2'($urandom),
              16'($urandom), 16'($urandom));
      default: tick();
    endcase
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) begin
      case ($urandom_range(19))
        0, 1, 2: noise();
        3, 4, 5, 6, 7, 8: new_task();
        default: repeat ($urandom_range(1, 4)) tick();
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero length, out of order slot, busy load and admit, zero burst,
    // unknown op, extreme fields, unreachable io start, very long io
    send(apts_pkg::OP_LOAD, 4'd0, 8'd0, 16'd0, 2'd0, 16'd0, 16'd0);
    send(apts_pkg::OP_LOAD, 4'd0, 8'd0, 16'd0, 2'd1, 16'd2, 16'd3);
    send(apts_pkg::OP_LOAD, 4'd0, 8'd0, 16'd0, 2'd3, 16'd1, 16'd1);
    send(apts_pkg::OP_ADMIT, 4'd0, 8'd0, 16'd5, 2'd0, 16'd0, 16'd0);
    send(apts_pkg::OP_ADMIT, 4'd1, 8'hFF, 16'd0, 2'd0, 16'd0, 16'd0);
    send(apts_pkg::OP_ADMIT, 4'd0, 8'd7, 16'd9, 2'd0, 16'd0, 16'd0);
    send(apts_pkg::OP_LOAD, 4'd0, 8'd0, 16'd0, 2'd0, 16'd4, 16'd4);
    send(OP_UNUSED, 4'hF, 8'hFF, 16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF);
    tick();
    tick();
    send(apts_pkg::OP_LOAD, 4'd2, 8'd0, 16'd0, 2'd0, 16'hFFFF, 16'd1);
    send(apts_pkg::OP_ADMIT, 4'd2, 8'hAA, 16'd2, 2'd0, 16'd0, 16'd0);
    send(apts_pkg::OP_LOAD, 4'd3, 8'd0, 16'd0, 2'd0, 16'd2, 16'd1);
    send(apts_pkg::OP_LOAD, 4'd3, 8'd0, 16'd0, 2'd1, 16'd1, 16'd1);
    send(apts_pkg::OP_ADMIT, 4'd3, 8'd1, 16'd4, 2'd0, 16'd0, 16'd0);
    send(apts_pkg::OP_LOAD, 4'd14, 8'd0, 16'd0, 2'd0, 16'd0, 16'hFFFF);
    send(apts_pkg::OP_ADMIT, 4'd14, 8'h80, 16'd3, 2'd0, 16'd0, 16'd0);
    send(apts_pkg::OP_ADMIT, 4'd15, 8'hFF, 16'hFFFF, 2'd0, 16'd0, 16'd0);
    repeat (7) tick();
    drain();

    write_cfg(apts_pkg::CFG_AGING, 8'd1);
    write_cfg(apts_pkg::CFG_FLOOR, 8'd0);
    random_phase(150);
    drain();

    send_idle_pct = 87;
    write_cfg(apts_pkg::CFG_AGING, 8'd255);
    write_cfg(apts_pkg::CFG_FLOOR, 8'd255);
    random_phase(150);
    drain();

    send_idle_pct = 0;
    stall_pct = 87;
    write_cfg(apts_pkg::CFG_AGING, 8'd0);
    write_cfg(apts_pkg::CFG_FLOOR, 8'd100);
    hold_ask++;
    random_phase(150);
    drain();

    send_idle_pct = 34;
    stall_pct = 34;
    write_cfg(apts_pkg::CFG_AGING, 8'($urandom_range(1, 20)));
    write_cfg(apts_pkg::CFG_FLOOR, 8'($urandom_range(0, 60)));
    random_phase(150);
    drain();

    if (fail_count == 0) begin
      $display("tb_aging_priority_task_scheduler_top: PASS");
    end else begin
      $display("tb_aging_priority_task_scheduler_top: FAIL");
    end
    $finish;
  end

endmodule
